### hdl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// shared types and constants for the decimal text renderer
// ----------------------------------------------------------------------------
package dtc_pkg;

  // input value width and the padded width fed to the shift-add-3 unit
  localparam int VALUE_W   = 31;
  localparam int BIN_W     = 32;

  // binary bits folded into the bcd register per cycle
  localparam int CONV_BITS  = 2;
  localparam int CONV_STEPS = BIN_W / CONV_BITS;
  localparam int STEP_W     = $clog2(CONV_STEPS);

  // character codes
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  // digits between commas
  localparam int GROUP_SIZE = 3;

  // commands from the sequencer to the conversion unit
  typedef struct packed {
    logic load;         // take a new value, clear the bcd register
    logic dabble;       // fold CONV_BITS binary bits into the bcd register
    logic shift_digit;  // move the bcd register up by one digit
  } dtc_ctl_t;

endpackage

### hdl/decimal_text_with_thousands_commas_core.sv
// ----------------------------------------------------------------------------
// decimal_text_with_thousands_commas_core
// renders a non-negative integer as decimal ascii with thousands commas
// ----------------------------------------------------------------------------
// sequence: shift-add-3 conversion (2 bits a cycle), then the zero skip that drops
//   the leading zeros (up to MAX_DIGITS-1), then the output register is loaded
// throughput: one character per cycle while the sink is ready; input tready is low
//   from an input transfer until the last character of that number is registered
// reset: rst synchronous active high, clears the sequencer and output valid
module decimal_text_with_thousands_commas_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] pad, ignored
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast    // is_last
);
  import dtc_pkg::*;

  localparam int         CW       = $clog2(MAX_DIGITS + 1);
  localparam logic [1:0] GRP_INIT = 2'((MAX_DIGITS - 1) % GROUP_SIZE);
  localparam logic [1:0] GRP_TOP  = 2'(GROUP_SIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t          state;
  logic [STEP_W-1:0] step;
  logic [CW-1:0]   cnt;
  logic [1:0]      grp;
  logic [1:0]      grp_next;
  logic            comma_pend;
  logic [3:0]      top_digit;
  logic            out_free;
  logic            skip_go;
  logic            emit_digit;
  logic            in_xfer;
  dtc_ctl_t        ctl;

  // handshake and sequencer decode
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign skip_go       = (state == S_SKIP) && (cnt > CW'(1)) && (top_digit == 4'd0);
  assign emit_digit    = (state == S_EMIT) && out_free && !comma_pend;
  assign grp_next      = (grp == 2'd0) ? GRP_TOP : grp - 2'd1;

  // commands to the conversion unit
  always_comb begin
    ctl.load        = in_xfer;
    ctl.dabble      = (state == S_CONV);
    ctl.shift_digit = skip_go || emit_digit;
  end

  dtc_dabble #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .ctl       (ctl),
    .value     (s_axis_tdata[VALUE_W-1:0]),
    .top_digit (top_digit)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      comma_pend    <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state      <= S_CONV;
            step       <= '0;
            cnt        <= CW'(MAX_DIGITS);
            grp        <= GRP_INIT;
            comma_pend <= 1'b0;
          end
        end
        S_CONV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(CONV_STEPS - 1)) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (skip_go) begin
            cnt <= cnt - 1'b1;
            grp <= grp_next;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            if (comma_pend) begin
              m_axis_tdata <= COMMA_CHAR;
              m_axis_tlast <= 1'b0;
              comma_pend   <= 1'b0;
            end else begin
              m_axis_tdata <= ASCII_ZERO + {4'd0, top_digit};
              m_axis_tlast <= (cnt == CW'(1));
              comma_pend   <= (cnt > CW'(1)) && (grp == 2'd0);
              cnt          <= cnt - 1'b1;
              grp          <= grp_next;
              if (cnt == CW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/dtc_dabble.sv
// ----------------------------------------------------------------------------
// dtc_dabble
// shift-add-3 binary to bcd unit, also shifts digits out from the top
// ----------------------------------------------------------------------------
module dtc_dabble #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                       clk,
  input  dtc_pkg::dtc_ctl_t          ctl,
  input  logic [dtc_pkg::VALUE_W-1:0] value,
  output logic [3:0]                 top_digit
);
  import dtc_pkg::*;

  localparam int BW = 4 * MAX_DIGITS;

  logic [BIN_W-1:0] bin;
  logic [BW-1:0]    bcd;
  logic [BIN_W-1:0] bin_next;
  logic [BW-1:0]    bcd_next;

  // CONV_BITS rounds of add-3 correction and shift; digits beyond the top
  // fall off, which keeps the value modulo 10^MAX_DIGITS
  always_comb begin
    bin_next = bin;
    bcd_next = bcd;
    for (int s = 0; s < CONV_BITS; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BW-2:0], bin_next[BIN_W-1]};
      bin_next = bin_next << 1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bin <= {{(BIN_W-VALUE_W){1'b0}}, value};
      bcd <= '0;
    end else if (ctl.dabble) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end else if (ctl.shift_digit) begin
      bcd <= bcd << 4;
    end
  end

  assign top_digit = bcd[BW-1 -: 4];

endmodule

### hdl/dtc_checker.sv
// ----------------------------------------------------------------------------
// dtc_checker
// port-level checks for the decimal text renderer
// ----------------------------------------------------------------------------
module dtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);
  import dtc_pkg::*;

  logic [1:0] open_cnt;
  logic       in_xfer;
  logic       out_xfer;
  logic       out_done;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_done = out_xfer && m_axis_tlast;

  // numbers open from their input transfer to their last character transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= 2'd0;
    end else if (in_xfer && !out_done) begin
      open_cnt <= open_cnt + 2'd1;
    end else if (out_done && !in_xfer) begin
      open_cnt <= open_cnt - 2'd1;
    end
  end

  // stalled output holds its character
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // a new number only once the previous text is down to its last character
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    in_xfer |->
      (open_cnt == 2'd0) ||
      (open_cnt == 2'd1 && m_axis_tvalid && m_axis_tlast))
    else $error("input taken while a number is still open");

  // characters only belong to an open number
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (open_cnt != 2'd0))
    else $error("character shown with no number open");

  // only digits and commas, and text never ends on a comma
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata >= ASCII_ZERO && m_axis_tdata <= ASCII_ZERO + 8'd9) ||
       (m_axis_tdata == COMMA_CHAR && !m_axis_tlast)))
    else $error("bad character or trailing comma");

  // input is blocked again right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("ready right after an input transfer");

endmodule

bind decimal_text_with_thousands_commas_core dtc_checker u_dtc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### dv/tb_decimal_text_with_thousands_commas_core.sv
// ----------------------------------------------------------------------------
// tb_decimal_text_with_thousands_commas_core
// self-checking bench for the decimal text renderer: numbers go in on the
// input stream, a local text predictor queues the characters each number
// should produce, and every output transfer is compared with the oldest one
// ----------------------------------------------------------------------------
module tb_decimal_text_with_thousands_commas_core;
  import dtc_pkg::*;

  localparam int MAX_DIGITS   = 10;
  localparam int IDLE_PCT     = 31;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_SHOWN    = 10;

  // one expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [30:0] value, [31] pad, ignored
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] text_char
  logic        m_axis_tlast;   // is_last

  text_char_t text_q[$];
  int         err_cnt;
  bit         steady;     // no idling on either side while set
  bit         hold_req;   // asks the sink for a hold-off, cleared by the sink when it ends

  decimal_text_with_thousands_commas_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // queue the characters that one input word should render to
  function automatic void predict_text(input logic [31:0] word);
    int unsigned rem;
    int unsigned digs[20];
    int          n;
    int          i;
    rem = word[30:0];
    n = 0;
    do begin
      digs[n] = rem % 10;
      rem = rem / 10;
      n++;
    end while (rem != 0 && n < MAX_DIGITS);
    // drop leading zeros left after truncation
    while (n > 1 && digs[n-1] == 0) n--;
    for (i = n - 1; i >= 0; i--) begin
      text_q.push_back('{ch: ASCII_ZERO + 8'(digs[i]), last: (i == 0)});
      if (i > 0 && (i % GROUP_SIZE) == 0) text_q.push_back('{ch: COMMA_CHAR, last: 1'b0});
    end
  endfunction

  // random value: a quarter of the time any 31-bit value, else a uniform spread over digit counts
  function automatic logic [30:0] rand_value();
    int unsigned digits;
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(3) == 0) return 31'($urandom);
    digits = $urandom_range(10, 1);
    p = 1;
    repeat (digits - 1) p = p * 10;
    lo = (digits == 1) ? 0 : p;
    hi = (digits == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
    return 31'($urandom_range(hi, lo));
  endfunction

  // offer one word and wait for its transfer; called and left at a falling edge
  task automatic send_word(input logic [31:0] word);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 32'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    do @(posedge clk); while (!s_axis_tready);
    predict_text(word);
    @(negedge clk);
  endtask

  task automatic send_value(input logic [30:0] v);
    send_word({1'b0, v});
  endtask

  // stop offering and wait until every queued character has come out or the drain limit is reached
  task automatic wait_drained();
    int n;
    s_axis_tvalid = 1'b0;
    n = 0;
    while (text_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // zero, digit-count boundaries, comma positions and the largest value
  task automatic test_boundaries();
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'd9);
    send_value(31'd10);
    send_value(31'd99);
    send_value(31'd100);
    send_value(31'd999);
    send_value(31'd1000);
    send_value(31'd9999);
    send_value(31'd10000);
    send_value(31'd99999);
    send_value(31'd100000);
    send_value(31'd999999);
    send_value(31'd1000000);
    send_value(31'd999999999);
    send_value(31'd1000000000);
    send_value(31'd1000000001);
    send_value(31'd100200300);
    send_value(31'h5555_5555);
    send_value(31'h2AAA_AAAA);
    send_value(31'h7FFF_FFFF);
  endtask

  // the pad bit above the value must be ignored
  task automatic test_pad_bit();
    send_word(32'h8000_0000);
    send_word(32'h8000_0000 | 32'd1234567);
    send_word(32'hFFFF_FFFF);
  endtask

  // sink stalls for a long time while the source keeps offering
  task automatic test_sink_holdoff();
    hold_req = 1'b1;
    repeat (6) send_value(rand_value());
    wait (!hold_req);
  endtask

  // source goes quiet until the block has emptied, then resumes
  task automatic test_source_pause();
    repeat (10) send_value(rand_value());
    wait_drained();
    repeat (10) send_value(rand_value());
  endtask

  // back-to-back transfers with both sides always ready
  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (150) send_value(rand_value());
    steady = 1'b0;
  endtask

  // random values with random idling on both sides
  task automatic test_random_values();
    repeat (300) send_value(rand_value());
  endtask

  // output sink with random ready and an occasional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each output transfer with the oldest expected character
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (text_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected char: got %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = text_q.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("char mismatch: expected %h last %b, got %h last %b",
                     want.ch, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // test sequence
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_cnt       = 0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_boundaries();
    test_pad_bit();
    test_sink_holdoff();
    test_source_pause();
    test_steady_stream();
    test_random_values();
    wait_drained();

    // anything still queued never came out
    if (text_q.size() != 0) begin
      err_cnt += text_q.size();
      if (err_cnt <= MAX_SHOWN)
        $display("missing chars: %0d still expected", text_q.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
